@@ src/i2c_temp_sensor_reader_core_assert.svh @@
// Assertion macros for the I2C temperature reader core.
// Requires clk and rst_n in the scope of each use.
`ifndef I2C_TEMP_SENSOR_READER_CORE_ASSERT_SVH
`define I2C_TEMP_SENSOR_READER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ITSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itsr: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define ITSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itsr: next-cycle check failed");

`endif

@@ src/itsr_pkg.sv @@
// Shared types, step codes and pin-phase functions for the I2C temperature reader.
// No dependencies.
`default_nettype none

package itsr_pkg;

  localparam int TICK_BITS_DEF = 16;
  localparam int PHASE_W       = 16;
  localparam logic [PHASE_W-1:0] PHASE_RST = 16'd100;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_START0  = 4'd1;
  localparam logic [3:0] ST_START1  = 4'd5;
  localparam logic [3:0] ST_START2  = 4'd8;
  localparam logic [3:0] ST_START3  = 4'd11;
  localparam logic [3:0] ST_WADDR0  = 4'd2;
  localparam logic [3:0] ST_WCMD_AC = 4'd3;
  localparam logic [3:0] ST_WCFG    = 4'd4;
  localparam logic [3:0] ST_WADDR1  = 4'd6;
  localparam logic [3:0] ST_WCMD_EE = 4'd7;
  localparam logic [3:0] ST_WADDR2  = 4'd9;
  localparam logic [3:0] ST_WCMD_AA = 4'd10;
  localparam logic [3:0] ST_READ_HI = 4'd13;
  localparam logic [3:0] ST_READ_LO = 4'd14;
  localparam logic [3:0] ST_STOP    = 4'd15;

  localparam logic [7:0] ADDR_WR  = 8'h90;
  localparam logic [7:0] ADDR_RD  = 8'h91;
  localparam logic [7:0] CMD_AC   = 8'hAC;
  localparam logic [7:0] CFG_VAL  = 8'h20;
  localparam logic [7:0] CMD_EE   = 8'hEE;
  localparam logic [7:0] CMD_AA   = 8'hAA;

  localparam logic signed [15:0] TEMP_MIN   = -16'sd14080;
  localparam logic [15:0]        TEMP_FLOOR = 16'h9D00;

  typedef struct packed {
    logic [3:0]  step;
    logic [2:0]  sub_ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift_b;
    logic [7:0]  high_b;
    logic [2:0]  addr;
    logic [15:0] result;
    logic        err;
  } itsr_state_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
    logic busy;
    logic done;
  } itsr_flags_t;

  function automatic logic is_start_step(input logic [3:0] s);
    return (s == ST_START0) || (s == ST_START1) || (s == ST_START2) || (s == ST_START3);
  endfunction

  function automatic logic is_read_step(input logic [3:0] s);
    return (s == ST_READ_HI) || (s == ST_READ_LO);
  endfunction

  function automatic logic [7:0] write_byte(input logic [3:0] s, input logic [2:0] a);
    logic [7:0] a2;
    a2 = {4'b0000, a, 1'b0};
    case (s)
      ST_WADDR0, ST_WADDR1, ST_WADDR2: write_byte = ADDR_WR + a2;
      ST_WCMD_AC: write_byte = CMD_AC;
      ST_WCFG:    write_byte = CFG_VAL;
      ST_WCMD_EE: write_byte = CMD_EE;
      ST_WCMD_AA: write_byte = CMD_AA;
      default:    write_byte = ADDR_RD + a2;
    endcase
  endfunction

  // {scl, sda, drive} for the current phase
  function automatic logic [2:0] phase_pins(input itsr_state_t st);
    logic       hi;
    logic [7:0] wb;
    hi = (st.sub_ph == 3'd0);
    wb = write_byte(st.step, st.addr);
    if (st.step == ST_IDLE) begin
      phase_pins = 3'b111;
    end else if (is_start_step(st.step)) begin
      if (st.sub_ph == 3'd0) begin
        phase_pins = 3'b111;
      end else if (st.sub_ph == 3'd1) begin
        phase_pins = 3'b101;
      end else begin
        phase_pins = 3'b001;
      end
    end else if (st.step == ST_STOP) begin
      phase_pins = {1'b1, !hi, 1'b1};
    end else if (is_read_step(st.step)) begin
      if (st.bit_cnt < 4'd8) begin
        phase_pins = {hi, 1'b0, 1'b0};
      end else begin
        phase_pins = {hi, (st.step == ST_READ_LO), 1'b1};
      end
    end else if (st.bit_cnt < 4'd8) begin
      phase_pins = {hi, wb[3'd7 - st.bit_cnt[2:0]], 1'b1};
    end else begin
      phase_pins = {hi, 1'b0, 1'b0};
    end
  endfunction

endpackage

`default_nettype wire

@@ src/itsr_step.sv @@
// Next-state and pin logic of the I2C read sequencer for one tick.
// Depends on itsr_pkg.
`default_nettype none

module itsr_step
  import itsr_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  itsr_state_t          cur,
  input  logic [TICK_BITS-1:0] tick,
  input  logic [PHASE_W-1:0]   phase_ticks,
  input  logic                 start_request,
  input  logic [2:0]           sensor_select,
  input  logic                 sda_in,
  output itsr_state_t          nxt,
  output logic [TICK_BITS-1:0] tick_nxt,
  output itsr_flags_t          flags
);

  localparam int CW = (TICK_BITS > PHASE_W) ? TICK_BITS : PHASE_W;
  localparam logic [CW-1:0] MASK = CW'((64'd1 << TICK_BITS) - 64'd1);

  logic [PHASE_W-1:0] last16;
  logic [CW-1:0]      last_ext;
  logic [CW-1:0]      lim;
  logic [2:0]         pins;
  logic               adv;
  logic               fin;
  logic [15:0]        word;

  always_comb begin
    last16   = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
    last_ext = CW'(last16);
    lim      = (last_ext > MASK) ? MASK : last_ext;
  end

  always_comb begin
    nxt      = cur;
    tick_nxt = tick;
    adv      = 1'b0;
    fin      = 1'b0;
    word     = {cur.high_b, cur.shift_b};
    flags    = '0;

    if (cur.step == ST_IDLE && start_request) begin
      nxt.addr    = sensor_select;
      nxt.step    = ST_START0;
      nxt.sub_ph  = 3'd0;
      nxt.bit_cnt = 4'd0;
      tick_nxt    = '0;
    end

    pins      = phase_pins(nxt);
    flags.scl = pins[2];
    flags.sda = pins[1];
    flags.drv = pins[0];

    if (nxt.step != ST_IDLE) begin
      flags.busy = 1'b1;
      if (CW'(tick_nxt) >= lim) begin
        tick_nxt = '0;
        if (is_start_step(nxt.step)) begin
          if (nxt.sub_ph >= 3'd2) begin
            adv = 1'b1;
          end else begin
            nxt.sub_ph = nxt.sub_ph + 3'd1;
          end
        end else if (nxt.step == ST_STOP) begin
          if (nxt.sub_ph >= 3'd1) begin
            fin = 1'b1;
          end else begin
            nxt.sub_ph = nxt.sub_ph + 3'd1;
          end
        end else if (nxt.sub_ph == 3'd0) begin
          if (is_read_step(nxt.step) && nxt.bit_cnt < 4'd8) begin
            nxt.shift_b = {nxt.shift_b[6:0], sda_in};
          end
          nxt.sub_ph = 3'd1;
        end else begin
          nxt.sub_ph = 3'd0;
          if (nxt.bit_cnt >= 4'd8) begin
            adv = 1'b1;
          end else begin
            nxt.bit_cnt = nxt.bit_cnt + 4'd1;
          end
        end
      end else begin
        tick_nxt = tick_nxt + 1'b1;
      end
    end

    if (adv) begin
      if (nxt.step == ST_READ_HI) begin
        nxt.high_b = nxt.shift_b;
      end
      nxt.step    = nxt.step + 4'd1;
      nxt.sub_ph  = 3'd0;
      nxt.bit_cnt = 4'd0;
      if (is_read_step(nxt.step)) begin
        nxt.shift_b = 8'd0;
      end
    end

    if (fin) begin
      word = {nxt.high_b, nxt.shift_b};
      if ($signed(word) < TEMP_MIN) begin
        nxt.result = TEMP_FLOOR;
        nxt.err    = 1'b1;
      end else begin
        nxt.result = word;
        nxt.err    = 1'b0;
      end
      nxt.step    = ST_IDLE;
      nxt.sub_ph  = 3'd0;
      nxt.bit_cnt = 4'd0;
      flags.done  = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ src/i2c_temp_sensor_reader_core.sv @@
// Top level of the bit-banged I2C temperature reader: stream ports, state and output registers.
// Depends on itsr_pkg, itsr_step and i2c_temp_sensor_reader_core_assert.svh.
//
//   channel | dir | beat
//   in_     | in  | one tick: start_request, sensor_select, sda_in
//   out_    | out | one per tick: pin levels, busy, done, temperature, flag
//   cfg_    | in  | phase_ticks write, 16 bits
//
// One beat per clock while out_ is not stalled; each beat's result is registered for the next cycle.
// The output register lets a new beat in while the last one is being taken.
// A stalled output holds in_tready low; the sequencer advances only on input beats.
// Synchronous active-low reset returns to idle with phase_ticks = 100.
`default_nettype none
`include "i2c_temp_sensor_reader_core_assert.svh"

module i2c_temp_sensor_reader_core
  import itsr_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [0] start_request, [3:1] sensor_select, [4] sda_in
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // [0] scl_level, [1] sda_level, [2] sda_drive,
                                         // [3] busy_res, [4] done_res, [20:5] temperature,
                                         // [21] out_of_range
  input  logic               cfg_wr_en,
  input  logic [PHASE_W-1:0] cfg_wr_data
);

  itsr_state_t          st_r, st_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [PHASE_W-1:0]   phase_r;
  itsr_flags_t          flags;
  logic                 out_valid_r;
  logic [23:0]          out_data_r;
  logic                 in_acc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  itsr_step #(
    .TICK_BITS(TICK_BITS)
  ) u_step (
    .cur          (st_r),
    .tick         (tick_r),
    .phase_ticks  (phase_r),
    .start_request(in_tdata[0]),
    .sensor_select(in_tdata[3:1]),
    .sda_in       (in_tdata[4]),
    .nxt          (st_nxt),
    .tick_nxt     (tick_nxt),
    .flags        (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_RST;
    end else if (cfg_wr_en) begin
      phase_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      tick_r <= '0;
    end else if (in_acc) begin
      st_r   <= st_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {2'b00, st_nxt.err, st_nxt.result, flags.done, flags.busy,
                     flags.drv, flags.sda, flags.scl};
    end
  end

  `ITSR_ASSERT_NEXT(a_idle_stays, in_acc && st_r.step == ST_IDLE && !in_tdata[0], st_r.step == ST_IDLE)
  `ITSR_ASSERT_NOW(a_done_idle, out_valid_r && out_data_r[4], st_r.step == ST_IDLE)
  `ITSR_ASSERT_NOW(a_notbusy_idle, out_valid_r && !out_data_r[3], st_r.step == ST_IDLE)
  `ITSR_ASSERT_NOW(a_flag_floor, st_r.err, st_r.result == TEMP_FLOOR)
  `ITSR_ASSERT_NOW(a_sub_range, 1'b1, st_r.sub_ph <= 3'd2)

endmodule

`default_nettype wire
